FILE: rtl/sde_pkg.sv
package sde_pkg;

  localparam int RawWidth = 8;

  // result kinds
  localparam logic [2:0] KIND_SWITCH  = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_PRESS   = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_REPORT  = 3'd4;

  // register indexes
  localparam logic REG_KEY_BIT = 1'b0;

  typedef struct packed {
    logic [7:0] raw_port_a;
    logic [7:0] raw_port_b;
    logic       events_enabled;
  } sde_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] event_value;
    logic        last;
  } sde_out_t;

  // what one sample leaves for the emitter to walk through
  typedef struct packed {
    logic [7:0] new_a;
    logic [7:0] new_b;
    logic       sw_pend;
    logic       key_pend;
    logic       unlocked;
    logic [7:0] btn_mask;
  } sde_rec_t;

endpackage

FILE: rtl/sde_detect.sv
module sde_detect import sde_pkg::*; #(
  parameter int PORT_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  sde_in_t    in_data,
  input  logic [2:0] key_bit,
  output sde_rec_t   rec
);

  localparam logic [7:0] PortMask = 8'((16'd1 << PORT_WIDTH) - 16'd1);

  logic [7:0] prev_a_r, prev_b_r, stable_a_r, stable_b_r;
  logic [7:0] raw_a, raw_b, new_a, new_b, diff_a, diff_b, kb;
  logic       changed;

  always_comb begin
    raw_a   = in_data.raw_port_a & PortMask;
    raw_b   = in_data.raw_port_b & PortMask;
    new_a   = (raw_a == prev_a_r) ? raw_a : stable_a_r;
    new_b   = (raw_b == prev_b_r) ? raw_b : stable_b_r;
    diff_a  = new_a ^ stable_a_r;
    diff_b  = new_b ^ stable_b_r;
    kb      = 8'd1 << key_bit;
    changed = in_data.events_enabled && ((diff_a != 8'd0) || (diff_b != 8'd0));

    rec.new_a    = new_a;
    rec.new_b    = new_b;
    rec.sw_pend  = changed;
    rec.key_pend = changed && ((diff_a & kb) != 8'd0);
    rec.unlocked = ((new_a & kb) == 8'd0);
    rec.btn_mask = changed ? diff_b : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r   <= PortMask;
      prev_b_r   <= PortMask;
      stable_a_r <= PortMask;
      stable_b_r <= PortMask;
    end else if (accept) begin
      prev_a_r   <= raw_a;
      prev_b_r   <= raw_b;
      stable_a_r <= new_a;
      stable_b_r <= new_b;
    end
  end

endmodule

FILE: rtl/sde_emit.sv
module sde_emit import sde_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  sde_rec_t rec_in,
  output logic     can_load,
  output logic     out_valid,
  input  logic     out_ready,
  output sde_out_t out_data
);

  sde_rec_t   rec_r, rec_nxt;
  logic       rec_v_r, rec_v_nxt;
  logic       out_v_r, out_v_nxt;
  sde_out_t   out_r, out_nxt;
  logic       adv, done;
  logic [2:0] bit_idx;
  logic       bit_val;

  assign adv      = !out_v_r || out_ready;
  assign done     = !rec_r.sw_pend && !rec_r.key_pend && (rec_r.btn_mask == 8'd0);
  assign can_load = !rec_v_r || (adv && done);

  // lowest pending button bit
  always_comb begin
    bit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rec_r.btn_mask[i]) bit_idx = 3'(i);
    end
    bit_val = rec_r.new_b[bit_idx];
  end

  always_comb begin
    rec_nxt   = rec_r;
    rec_v_nxt = rec_v_r;
    out_v_nxt = out_v_r && !out_ready;
    out_nxt   = out_r;
    if (adv && rec_v_r) begin
      out_v_nxt = 1'b1;
      out_nxt.last = 1'b0;
      if (rec_r.sw_pend) begin
        out_nxt.event_kind  = KIND_SWITCH;
        out_nxt.event_value = {rec_r.new_a, rec_r.new_b};
        rec_nxt.sw_pend     = 1'b0;
      end else if (rec_r.key_pend) begin
        out_nxt.event_kind  = KIND_KEY;
        out_nxt.event_value = {15'd0, rec_r.unlocked};
        rec_nxt.key_pend    = 1'b0;
      end else if (rec_r.btn_mask != 8'd0) begin
        out_nxt.event_kind  = bit_val ? KIND_RELEASE : KIND_PRESS;
        out_nxt.event_value = {13'd0, bit_idx};
        rec_nxt.btn_mask[bit_idx] = 1'b0;
      end else begin
        out_nxt.event_kind  = KIND_REPORT;
        out_nxt.event_value = {rec_r.new_a, rec_r.new_b};
        out_nxt.last        = 1'b1;
        rec_v_nxt           = 1'b0;
      end
    end
    if (load) begin
      rec_nxt   = rec_in;
      rec_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      rec_v_r <= rec_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/switch_debounce_edge_events_top.sv
// two-sample switch debounce with edge events
// in_*: one request per sample of ports a and b plus the events-enabled flag
// out_*: result requests; each sample gives a run of one to eleven results,
//   switch change, key lock change, press/release per port-b bit from bit 0,
//   then a state report with last set
// cfg_*: apb write/read of key_bit at byte address 0, pready tied high
// the first result of a sample passes through the run register, then the result register
// throughput: a sample's run occupies the emitter until its report is issued; the emitter
//   walks one result per cycle while the result register is not stalled, and the next
//   sample is taken in the cycle the current run's report goes out
// debounce state (previous raw, stable) updates when the sample is accepted
// reset: rst_n synchronous active low; all ports read as released (all
//   ones), key_bit is 0, no results pending
// stall: the result register holds while out_ready is low; one sample waits
//   in the run register, further samples are held off by in_ready
module switch_debounce_edge_events_top import sde_pkg::*; #(
  parameter int PORT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sde_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sde_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [2:0] key_bit_r;
  logic       reg_idx;
  logic       accept;
  sde_rec_t   rec;

  // register index is the word address
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_KEY_BIT) ? {29'd0, key_bit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bit_r <= 3'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (reg_idx == REG_KEY_BIT)) begin
      key_bit_r <= cfg_pwdata[2:0];
    end
  end

  // a sample is taken once the emitter can hold its run
  assign accept = in_valid && in_ready;

  sde_detect #(
    .PORT_WIDTH(PORT_WIDTH)
  ) u_detect (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .key_bit (key_bit_r),
    .rec     (rec)
  );

  sde_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .rec_in    (rec),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/sde_checker.sv
module sde_checker import sde_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sde_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // last marks the state report and nothing else
  a_last_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.event_kind == KIND_REPORT)))
    else $error("last flag does not match report");

  // only defined kinds, key value is a flag, button index within port
  a_kind_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_kind == KIND_SWITCH ||
                   out_data.event_kind == KIND_REPORT ||
                   (out_data.event_kind == KIND_KEY && out_data.event_value <= 16'd1) ||
                   ((out_data.event_kind == KIND_PRESS ||
                     out_data.event_kind == KIND_RELEASE) &&
                    out_data.event_value <= 16'd7)))
    else $error("bad result kind or value");

  // a run's next sample cannot enter while a non-final result is stalled
  a_no_take_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_data.last && $past(out_valid && !out_ready)
    |-> !(in_valid && in_ready && $past(in_valid && in_ready)))
    else $error("two samples taken while run stalled");

  // the first result after an idle output comes from an accepted sample
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind switch_debounce_edge_events_top sde_checker u_sde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/sde_event_checker.sv
module sde_event_checker import sde_pkg::*; #(
  parameter int PortWidth = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  sde_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  sde_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          due_count,
  output int          fail_count
);

  localparam logic [2:0] KeyBitAddr = 3'(4 * REG_KEY_BIT);
  localparam logic [7:0] PortMask = 8'((9'd1 << PortWidth) - 9'd1);

  logic [7:0] raw_a_seen;
  logic [7:0] raw_b_seen;
  logic [7:0] steady_a;
  logic [7:0] steady_b;
  logic [2:0] key_pos;
  sde_out_t   due_events [$];
  int         errors;

  function automatic sde_out_t make_event(input logic [2:0] kind, input logic [15:0] value,
                                          input logic is_last);
    sde_out_t ev;
    ev.event_kind  = kind;
    ev.event_value = value;
    ev.last        = is_last;
    return ev;
  endfunction

  // two-sample debounce, then the event run for one sample
  task automatic debounce_and_scan(input sde_in_t s);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] next_a;
    logic [7:0] next_b;
    logic [7:0] moved_a;
    logic [7:0] moved_b;
    logic [7:0] key_mask;
    a = s.raw_port_a & PortMask;
    b = s.raw_port_b & PortMask;
    next_a = (a == raw_a_seen) ? a : steady_a;
    next_b = (b == raw_b_seen) ? b : steady_b;
    raw_a_seen = a;
    raw_b_seen = b;
    moved_a = next_a ^ steady_a;
    moved_b = next_b ^ steady_b;
    if (s.events_enabled && (moved_a != 8'd0 || moved_b != 8'd0)) begin
      due_events.push_back(make_event(KIND_SWITCH, {next_a, next_b}, 1'b0));
      key_mask = 8'd1 << key_pos;
      // key is active low: a low key bit means unlocked
      if ((moved_a & key_mask) != 8'd0) begin
        due_events.push_back(make_event(KIND_KEY, {15'd0, ~|(next_a & key_mask)}, 1'b0));
      end
      for (int i = 0; i < PortWidth; i++) begin
        if (moved_b[i]) begin
          due_events.push_back(make_event(next_b[i] ? KIND_RELEASE : KIND_PRESS,
                                          16'(i), 1'b0));
        end
      end
    end
    steady_a = next_a;
    steady_b = next_b;
    due_events.push_back(make_event(KIND_REPORT, {steady_a, steady_b}, 1'b1));
  endtask

  always @(posedge clk) begin
    sde_out_t want;
    if (!rst_n) begin
      raw_a_seen = 8'hFF & PortMask;
      raw_b_seen = 8'hFF & PortMask;
      steady_a   = 8'hFF & PortMask;
      steady_b   = 8'hFF & PortMask;
      key_pos    = 3'd0;
      errors     = 0;
      due_events.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == KeyBitAddr) begin
        key_pos = cfg_pwdata[2:0];
      end
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got kind %0d value %h last %b",
                   $time, out_data.event_kind, out_data.event_value, out_data.last);
        end else begin
          want = due_events.pop_front();
          if (out_data.event_kind !== want.event_kind ||
              out_data.event_value !== want.event_value ||
              out_data.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected kind %0d value %h last %b,",
                     $time, want.event_kind, want.event_value, want.last,
                     " got kind %0d value %h last %b",
                     out_data.event_kind, out_data.event_value, out_data.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        debounce_and_scan(in_data);
      end
    end
    due_count  <= due_events.size();
    fail_count <= errors;
  end

endmodule

FILE: test/switch_debounce_edge_events_top_tb.sv
module switch_debounce_edge_events_top_tb import sde_pkg::*;;

  localparam int PortW = 8;
  localparam logic [2:0] KeyBitAddr = 3'(4 * REG_KEY_BIT);
  // worst case is far below this even with every stall at its longest
  localparam int CycleLimit = 400000;
  // receiver hold-off that forces the block to back up its input
  localparam int LongHoldCycles = 120;
  localparam int LongHoldAfter = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sde_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  sde_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          due_count;
  int          fail_count;
  int          sent_count;
  int          cycle_count;
  bit          quiet_link;
  bit          long_hold_done;
  logic [2:0]  key_now;
  logic [7:0]  held_a;
  logic [7:0]  held_b;

  switch_debounce_edge_events_top #(
    .PORT_WIDTH(PortW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // watches all three ports, predicts every event run and counts failures
  sde_event_checker #(
    .PortWidth(PortW)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_pready (cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .due_count  (due_count),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop in case the block hangs or loses results
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("switch_debounce_edge_events_top verification failed");
    $finish;
  end

  // small random change of a port sample: none, one bit, the key bit, some bits or all new
  function automatic logic [7:0] nudge(input logic [7:0] v);
    case ($urandom_range(0, 4))
      0: return v;
      1: return v ^ (8'd1 << $urandom_range(0, 7));
      2: return v ^ (8'd1 << key_now);
      3: return v ^ 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one sample request, with a random gap before it unless the link is quiet
  task automatic offer_sample(input logic [7:0] a, input logic [7:0] b, input logic en);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_link || pick < 60) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data.raw_port_a     <= a;
    in_data.raw_port_b     <= b;
    in_data.events_enabled <= en;
    in_valid               <= 1'b1;
    // valid and payload stay put until the request is taken
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    // wait so the count includes the request taken in this step
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle; the write lands at the access edge
  task automatic write_key_bit(input logic [2:0] pos);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= KeyBitAddr;
    // upper bits carry junk, only the low three belong to the register
    cfg_pwdata  <= {29'($urandom), pos};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    key_now = pos;
  endtask

  // directed opening, run with key_bit at 0
  task automatic run_opening();
    offer_sample(8'hFF, 8'hFF, 1'b1);  // matches reset state: report only
    offer_sample(8'h00, 8'h00, 1'b1);  // first sighting, stable holds
    offer_sample(8'h00, 8'h00, 1'b1);  // longest run: switch, unlock, eight presses, report
    offer_sample(8'hFF, 8'hFF, 1'b1);
    offer_sample(8'hFF, 8'hFF, 1'b1);  // all released, key locked again
    offer_sample(8'hAA, 8'h55, 1'b0);
    offer_sample(8'hAA, 8'h55, 1'b0);  // events off: change swallowed, report still given
    offer_sample(8'hAA, 8'h55, 1'b1);  // no change left to report
    offer_sample(8'hAB, 8'h55, 1'b1);
    offer_sample(8'hAB, 8'h55, 1'b1);  // key bit rises alone: switch plus lock
    offer_sample(8'hAB, 8'h54, 1'b1);
    offer_sample(8'hAB, 8'h54, 1'b1);  // only port b bit 0 pressed
    offer_sample(8'hAF, 8'h54, 1'b1);
    offer_sample(8'hAF, 8'h54, 1'b1);  // port a change away from the key bit
    offer_sample(8'h00, 8'hFF, 1'b1);  // bouncing contacts, never twice the same
    offer_sample(8'hFF, 8'h00, 1'b1);
    offer_sample(8'hFF, 8'h00, 1'b1);  // settles: both ports change together
    offer_sample(8'h7F, 8'h80, 1'b1);
    offer_sample(8'h7F, 8'h80, 1'b0);  // settles while events are off
    offer_sample(8'h7E, 8'h80, 1'b1);
    offer_sample(8'h7E, 8'h80, 1'b1);  // key bit falls: unlocked
    offer_sample(8'h7E, 8'h80, 1'b1);
  endtask

  // mostly settle sequences with random content, some noise and bounce
  task automatic random_phase(input int count);
    int done_items;
    int pick;
    logic [7:0] a;
    logic [7:0] b;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(0, 99);
      a = nudge(held_a);
      b = nudge(held_b);
      if (pick < 70) begin
        // same sample two or three times so it settles, events mostly on
        repeat ($urandom_range(2, 3)) begin
          offer_sample(a, b, $urandom_range(0, 9) != 0);
          done_items++;
        end
        held_a = a;
        held_b = b;
      end else if (pick < 85) begin
        offer_sample(8'($urandom), 8'($urandom), 1'($urandom));
        done_items++;
      end else begin
        // bounce in the middle of a settle
        offer_sample(a, b, 1'b1);
        offer_sample(nudge(a), nudge(b), 1'b1);
        offer_sample(a, b, 1'b1);
        done_items += 3;
      end
    end
  endtask

  // result side pacing: short random stalls, the odd long one, and one long hold-off
  initial begin
    int run_len;
    int pick;
    int hold_cycles;
    logic level;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && sent_count >= LongHoldAfter) begin
        // sender keeps offering while results pile up behind us
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LongHoldCycles) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (quiet_link || pick < 65) begin
          level   = 1'b1;
          run_len = $urandom_range(1, 6);
        end else if (pick < 93) begin
          level   = 1'b0;
          run_len = $urandom_range(1, 3);
        end else begin
          level   = 1'b0;
          run_len = $urandom_range(8, 20);
        end
        out_ready <= level;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [2:0] key_choice;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    sent_count     = 0;
    quiet_link     = 1'b0;
    long_hold_done = 1'b0;
    key_now        = 3'd0;
    held_a         = 8'hFF;
    held_b         = 8'hFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // five phases, each writing its key position first; phase 1 runs with no idling
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: key_choice = 3'd0;
        1: key_choice = 3'd7;
        3: key_choice = 3'd3;
        default: key_choice = 3'($urandom_range(0, 7));
      endcase
      if (p > 0) begin
        drain_results();
      end
      quiet_link = (p == 1);
      write_key_bit(key_choice);
      if (p == 0) begin
        run_opening();
      end
      random_phase(72);
    end

    drain_results();
    // keep running so a stray result would still be caught
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("switch_debounce_edge_events_top verification clean");
    end else begin
      $display("switch_debounce_edge_events_top verification failed");
    end
    $finish;
  end

endmodule
